// ===== hw/rtl/wdsvc_pkg.sv =====
// Package for the watchdog service sequencer: word layouts, register codes,
// command helpers and the question answer table. No dependencies.
package wdsvc_pkg;

   localparam int CmdWidth   = 16;
   localparam int RegWidth   = 7;
   localparam int CountWidth = 6;

   // Register addresses of the driver chip.
   localparam logic [RegWidth-1:0] REG_WWD_SERVICE = 7'h15;
   localparam logic [RegWidth-1:0] REG_FWD_RESP    = 7'h16;
   localparam logic [RegWidth-1:0] REG_FWD_SYNC    = 7'h17;
   localparam logic [RegWidth-1:0] REG_WD_DIAG     = 7'h2e;
   localparam logic [RegWidth-1:0] REG_WWD_STAT    = 7'h36;
   localparam logic [RegWidth-1:0] REG_FWD_STAT0   = 7'h37;
   localparam logic [RegWidth-1:0] REG_FWD_STAT1   = 7'h38;
   localparam logic [RegWidth-1:0] REG_TEC_STAT    = 7'h39;

   localparam logic [7:0] WWD_SERVICE_DATA = 8'h03;

   // Input word kinds.
   localparam logic KIND_POLL  = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_WIN_INTERVAL = 1'b0;
   localparam logic CSR_FUN_PERIOD   = 1'b1;

   localparam logic [15:0] WIN_INTERVAL_RESET = 16'd10;
   localparam logic [15:0] FUN_PERIOD_RESET   = 16'd20;

   // Answer bytes, four per question, row by row.
   localparam logic [7:0] ANSWER_TABLE [64] = '{
      8'hFF, 8'h0F, 8'hF0, 8'h00,  8'hB0, 8'h40, 8'hBF, 8'h4F,
      8'hE9, 8'h19, 8'hE6, 8'h16,  8'hA6, 8'h56, 8'hA9, 8'h59,
      8'h75, 8'h85, 8'h7A, 8'h8A,  8'h3A, 8'hCA, 8'h35, 8'hC5,
      8'h63, 8'h93, 8'h6C, 8'h9C,  8'h2C, 8'hDC, 8'h23, 8'hD3,
      8'hD2, 8'h22, 8'hDD, 8'h2D,  8'h9D, 8'h6D, 8'h92, 8'h62,
      8'hC4, 8'h34, 8'hCB, 8'h3B,  8'h8B, 8'h7B, 8'h84, 8'h74,
      8'h58, 8'hA8, 8'h57, 8'hA7,  8'h17, 8'hE7, 8'h18, 8'hE8,
      8'h4E, 8'hBE, 8'h41, 8'hB1,  8'h01, 8'hF1, 8'h0E, 8'hFE
   };

   typedef struct packed {
      logic [15:0] win_interval;
      logic [15:0] fun_period;
   } cfg_type;

   typedef struct packed {
      logic [15:0] reply_word;
      logic [31:0] now_ticks;
      logic        kind;
   } item_type;

   typedef struct packed {
      logic [CountWidth-1:0] total_error_count;
      logic [CountWidth-1:0] functional_status_count;
      logic [CountWidth-1:0] window_error_count;
      logic                  reconfigure_request;
      logic                  watchdog_healthy;
      logic                  poll_done;
      logic                  send_valid;
      logic [CmdWidth-1:0]   command_word;
   } result_type;

   function automatic logic [CmdWidth-1:0] spi_read_word(input logic [RegWidth-1:0] addr);
      spi_read_word = {8'h00, addr, 1'b0};
   endfunction

   function automatic logic [CmdWidth-1:0] spi_write_word(input logic [RegWidth-1:0] addr,
                                                          input logic [7:0] data);
      spi_write_word = {data, addr, 1'b1};
   endfunction

   function automatic logic [RegWidth-1:0] reply_reg(input logic [CmdWidth-1:0] w);
      reply_reg = w[7:1];
   endfunction

   function automatic logic [CountWidth-1:0] count_of(input logic [CmdWidth-1:0] w);
      count_of = w[13:8];
   endfunction

endpackage

// ===== hw/rtl/engine_ic_watchdog_service_sequencer_top.sv =====
// Top level of the watchdog service sequencer for a 16-bit SPI driver chip.
// Depends on wdsvc_pkg, wdsvc_csr, wdsvc_in_reg and wdsvc_core.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_tvalid/tready    poll time or reply word, kind in tuser
//   rsp_     out        rsp_tvalid/tready    command word and status, poll end in tlast
//   csr_     in         csr_we               window interval, functional period
//
// One word is accepted per cycle while the result is not stalled; each word's result is
// valid after the input register and then the result register, around one step of logic.
// Reset is synchronous; it returns the sequencer to idle and the registers to defaults.
// A stalled result holds the core; a new word is then taken only while the input register
// is empty.
module engine_ic_watchdog_service_sequencer_top import wdsvc_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // now_ticks[31:0], reply_word[47:32]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // command_word[15:0], watchdog_healthy[16], reconfigure_request[17],
   // window_error_count[23:18], functional_status_count[29:24],
   // total_error_count[35:30], zero[39:36]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // send_valid
   output logic        rsp_tlast,   // poll_done
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg;
   item_type   in_item;
   item_type   item;
   logic       item_vld;
   logic       take;
   result_type res;

   assign in_item.kind       = req_tuser;
   assign in_item.now_ticks  = req_tdata[31:0];
   assign in_item.reply_word = req_tdata[47:32];

   wdsvc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wdsvc_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (in_item),
      .take     (take),
      .item_vld (item_vld),
      .item     (item)
   );

   wdsvc_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item_vld  (item_vld),
      .item      (item),
      .take      (take),
      .rsp_ready (rsp_tready),
      .res_vld   (rsp_tvalid),
      .res       (res)
   );

   assign rsp_tdata = {4'b0000,
                       res.total_error_count,
                       res.functional_status_count,
                       res.window_error_count,
                       res.reconfigure_request,
                       res.watchdog_healthy,
                       res.command_word};
   assign rsp_tuser = res.send_valid;
   assign rsp_tlast = res.poll_done;

endmodule

// ===== hw/rtl/wdsvc_csr.sv =====
// Configuration registers of the watchdog service sequencer.
// Depends on wdsvc_pkg for the register indexes and reset values.
module wdsvc_csr import wdsvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIN_INTERVAL: cfg_in.win_interval = csr_wdata;
            CSR_FUN_PERIOD:   cfg_in.fun_period   = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_interval <= WIN_INTERVAL_RESET;
         cfg_ff.fun_period   <= FUN_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/wdsvc_in_reg.sv =====
// Input register of the watchdog service sequencer: holds one word until
// the sequencer core takes it. Depends on wdsvc_pkg for the word type.
module wdsvc_in_reg import wdsvc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     take,
   output logic     item_vld,
   output item_type item
);

   logic     vld_ff;
   logic     vld_in;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   // A held word leaving this cycle frees the register for the next one.
   assign in_ready = !vld_ff || take;
   assign accept   = in_valid && in_ready;

   always_comb begin
      vld_in  = vld_ff && !take;
      item_in = item_ff;
      if (accept) begin
         vld_in  = 1'b1;
         item_in = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

// ===== hw/rtl/wdsvc_core.sv =====
// Sequencer core: step state, timestamps, status words and healthy flag,
// with the result register. Depends on wdsvc_pkg.
module wdsvc_core import wdsvc_pkg::*; #(
   parameter int TIME_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_vld,
   input  item_type   item,
   output logic       take,
   input  logic       rsp_ready,
   output logic       res_vld,
   output result_type res
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SERVICE,
      ST_QREAD,
      ST_QECHO,
      ST_ANSWER,
      ST_DIAG_A,
      ST_DIAG_B,
      ST_WWD_READ,
      ST_FWD0_READ,
      ST_TEC_A,
      ST_TEC_B
   } step_type;

   step_type              step_ff, step_in;
   logic [TIME_WIDTH-1:0] last_win_ff, last_win_in;
   logic [TIME_WIDTH-1:0] last_fun_ff, last_fun_in;
   logic                  fun_due_ff, fun_due_in;
   logic [CmdWidth-1:0]   wwd_word_ff, wwd_word_in;
   logic [CmdWidth-1:0]   fwd_word_ff, fwd_word_in;
   logic                  healthy_ff, healthy_in;
   logic                  res_vld_ff, res_vld_in;
   result_type            res_ff, res_in;

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] win_gap;
   logic [TIME_WIDTH-1:0] fun_gap;
   logic                  win_late;
   logic                  fun_late;
   logic                  emit;
   logic                  done;
   logic                  rise;
   logic [CmdWidth-1:0]   cmd;
   logic [7:0]            q_data;
   logic [7:0]            answer;
   logic [RegWidth-1:0]   answer_reg;

   assign take = item_vld && (!res_vld_ff || rsp_ready);

   assign now_t    = TIME_WIDTH'(item.now_ticks);
   assign win_gap  = now_t - last_win_ff;
   assign fun_gap  = now_t - last_fun_ff;
   assign win_late = win_gap > TIME_WIDTH'(cfg.win_interval);
   assign fun_late = fun_gap > TIME_WIDTH'(cfg.fun_period);

   // Question nibble picks the row; the response count picks the column from the right.
   assign q_data     = item.reply_word[15:8];
   assign answer     = ANSWER_TABLE[{q_data[3:0], ~q_data[5:4]}];
   assign answer_reg = (q_data[5:4] != 2'd0) ? REG_FWD_RESP : REG_FWD_SYNC;

   always_comb begin
      step_in     = step_ff;
      last_win_in = last_win_ff;
      last_fun_in = last_fun_ff;
      fun_due_in  = fun_due_ff;
      wwd_word_in = wwd_word_ff;
      fwd_word_in = fwd_word_ff;
      healthy_in  = healthy_ff;
      emit        = 1'b0;
      done        = 1'b0;
      rise        = 1'b0;
      cmd         = '0;

      if (take) begin
         if (item.kind == KIND_POLL) begin
            // A poll during a running sequence is dropped.
            if (step_ff == ST_IDLE) begin
               emit       = 1'b1;
               fun_due_in = fun_late;
               if (fun_late) begin
                  last_fun_in = now_t;
               end
               if (win_late) begin
                  last_win_in = now_t;
                  cmd         = spi_write_word(REG_WWD_SERVICE, WWD_SERVICE_DATA);
                  step_in     = ST_SERVICE;
               end else if (fun_late) begin
                  fun_due_in = 1'b0;
                  cmd        = spi_read_word(REG_FWD_STAT1);
                  step_in    = ST_QREAD;
               end else begin
                  cmd     = spi_read_word(REG_WWD_STAT);
                  step_in = ST_WWD_READ;
               end
            end
         end else begin
            emit = 1'b1;
            unique case (step_ff)
               ST_SERVICE: begin
                  if (fun_due_ff) begin
                     fun_due_in = 1'b0;
                     cmd        = spi_read_word(REG_FWD_STAT1);
                     step_in    = ST_QREAD;
                  end else begin
                     cmd     = spi_read_word(REG_WWD_STAT);
                     step_in = ST_WWD_READ;
                  end
               end
               ST_QREAD: begin
                  cmd     = spi_read_word(REG_WD_DIAG);
                  step_in = ST_QECHO;
               end
               ST_QECHO: begin
                  if (reply_reg(item.reply_word) == REG_FWD_STAT1) begin
                     cmd     = spi_write_word(answer_reg, answer);
                     step_in = ST_ANSWER;
                  end else begin
                     cmd     = spi_read_word(REG_WWD_STAT);
                     step_in = ST_WWD_READ;
                  end
               end
               ST_ANSWER: begin
                  cmd     = spi_read_word(REG_WD_DIAG);
                  step_in = ST_DIAG_A;
               end
               ST_DIAG_A: begin
                  cmd     = spi_read_word(REG_WD_DIAG);
                  step_in = ST_DIAG_B;
               end
               ST_DIAG_B: begin
                  cmd     = spi_read_word(REG_WWD_STAT);
                  step_in = ST_WWD_READ;
               end
               ST_WWD_READ: begin
                  cmd     = spi_read_word(REG_FWD_STAT0);
                  step_in = ST_FWD0_READ;
               end
               ST_FWD0_READ: begin
                  wwd_word_in = item.reply_word;
                  cmd         = spi_read_word(REG_TEC_STAT);
                  step_in     = ST_TEC_A;
               end
               ST_TEC_A: begin
                  fwd_word_in = item.reply_word;
                  cmd         = spi_read_word(REG_TEC_STAT);
                  step_in     = ST_TEC_B;
               end
               ST_TEC_B: begin
                  // The flag only moves when both status replies echo their addresses.
                  if (reply_reg(wwd_word_ff) == REG_WWD_STAT &&
                      reply_reg(fwd_word_ff) == REG_FWD_STAT0) begin
                     healthy_in = (count_of(wwd_word_ff) == '0) &&
                                  (count_of(fwd_word_ff) == '0);
                     rise       = !healthy_ff && healthy_in;
                  end
                  done    = 1'b1;
                  step_in = ST_IDLE;
               end
               default: begin
                  // A reply with no exchange outstanding is dropped.
                  emit    = 1'b0;
                  step_in = ST_IDLE;
               end
            endcase
         end
      end

      res_vld_in = res_vld_ff && !rsp_ready;
      res_in     = res_ff;
      if (take) begin
         res_vld_in                     = emit;
         res_in.command_word            = cmd;
         res_in.send_valid              = !done;
         res_in.poll_done               = done;
         res_in.watchdog_healthy        = healthy_in;
         res_in.reconfigure_request     = rise;
         res_in.window_error_count      = count_of(wwd_word_in);
         res_in.functional_status_count = count_of(fwd_word_in);
         res_in.total_error_count       = done ? count_of(item.reply_word) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= ST_IDLE;
         last_win_ff <= '0;
         last_fun_ff <= '0;
         fun_due_ff  <= 1'b0;
         wwd_word_ff <= '0;
         fwd_word_ff <= '0;
         healthy_ff  <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         step_ff     <= step_in;
         last_win_ff <= last_win_in;
         last_fun_ff <= last_fun_in;
         fun_due_ff  <= fun_due_in;
         wwd_word_ff <= wwd_word_in;
         fwd_word_ff <= fwd_word_in;
         healthy_ff  <= healthy_in;
         res_vld_ff  <= res_vld_in;
      end
      res_ff <= res_in;
   end

   assign res_vld = res_vld_ff;
   assign res     = res_ff;

   a_poll_gives_result: assert property (@(posedge clock) disable iff (reset)
      (take && item.kind == KIND_POLL && step_ff == ST_IDLE) |=>
         (res_vld_ff && res_ff.send_valid && step_ff != ST_IDLE))
      else $error("poll from idle did not produce a command");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (take && item.kind == KIND_REPLY && step_ff == ST_TEC_B) |=>
         (res_vld_ff && res_ff.poll_done && !res_ff.send_valid && step_ff == ST_IDLE))
      else $error("final status reply did not close the sequence");

   a_healthy_only_at_end: assert property (@(posedge clock) disable iff (reset)
      !(take && item.kind == KIND_REPLY && step_ff == ST_TEC_B) |=> $stable(healthy_ff))
      else $error("healthy flag changed outside the final status step");

   a_request_needs_healthy: assert property (@(posedge clock) disable iff (reset)
      (res_vld_ff && res_ff.reconfigure_request) |->
         (res_ff.poll_done && res_ff.watchdog_healthy && healthy_ff))
      else $error("reconfiguration requested without a healthy flag");

endmodule
